[rtl/mandelbrot_escape_time_assert.svh]
// Assertion macros shared by the escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// Condition in this cycle implies a condition in the same cycle
`define MEE_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("escape-time check failed");

// Condition in this cycle implies a condition in the next cycle
`define MEE_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("escape-time check failed");

`endif

[rtl/mee_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mee_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned ACC_W   = 128;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned OUT_W   = 16;
    localparam int unsigned N_CELLS = 4;

    // Word moving along the multiplier chain
    typedef struct packed {
        logic               valid;
        logic [1:0]         tag;
        logic               neg;
        logic [WORD_W-1:0]  ua;
        logic [WORD_W-1:0]  ub;
        logic [ACC_W-1:0]   acc;
    } mul_word_t;

    // Rounded product leaving the multiplier
    typedef struct packed {
        logic                      valid;
        logic [1:0]                tag;
        logic signed [WORD_W-1:0]  p;
    } mul_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SKIP_A,
        S_SKIP_B,
        S_ITER,
        S_MUL,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/mee_mul_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mee_mul_cell
    import mee_pkg::*;
#(
    parameter int unsigned PART = 0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire mul_word_t word_in,
    output mul_word_t      word_out
);

    localparam int unsigned SHIFT = ((PART & 1) + ((PART >> 1) & 1)) * 32;

    logic [31:0]      a_half;
    logic [31:0]      b_half;
    logic [63:0]      prod;
    mul_word_t        word_reg;
    mul_word_t        word_next;

    // Pick the halves this cell multiplies and add the partial product
    always_comb begin
        a_half = (((PART >> 1) & 1) == 1) ? word_in.ua[63:32] : word_in.ua[31:0];
        b_half = ((PART & 1) == 1) ? word_in.ub[63:32] : word_in.ub[31:0];
        prod = 64'(a_half) * 64'(b_half);
        word_next = word_in;
        word_next.acc = word_in.acc + (ACC_W'(prod) << SHIFT);
    end

    // Hand the word to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

`default_nettype wire

[rtl/mee_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module mee_mul
    import mee_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 60
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    input  wire logic [1:0]               in_tag,
    input  wire logic signed [WORD_W-1:0] in_a,
    input  wire logic signed [WORD_W-1:0] in_b,
    output mul_res_t                      res
);

    mul_word_t       head_reg;
    mul_word_t       head_next;
    mul_word_t       chain [N_CELLS+1];
    mul_res_t        res_reg;
    mul_res_t        res_next;
    logic [WORD_W-1:0] q;
    logic              rem;

    // Split operands into sign and magnitude
    always_comb begin
        head_next.valid = in_valid;
        head_next.tag   = in_tag;
        head_next.neg   = in_a[WORD_W-1] ^ in_b[WORD_W-1];
        head_next.ua    = in_a[WORD_W-1] ? WORD_W'(-in_a) : WORD_W'(in_a);
        head_next.ub    = in_b[WORD_W-1] ? WORD_W'(-in_b) : WORD_W'(in_b);
        head_next.acc   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
        end else begin
            head_reg <= head_next;
        end
    end

    assign chain[0] = head_reg;

    // One partial product per cell
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        mee_mul_cell #(.PART(k)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .word_in  (chain[k]),
            .word_out (chain[k+1])
        );
    end

    // Scale down and round toward minus infinity
    always_comb begin
        q   = chain[N_CELLS].acc[FRAC_BITS +: WORD_W];
        rem = |chain[N_CELLS].acc[FRAC_BITS-1:0];
        res_next.valid = chain[N_CELLS].valid;
        res_next.tag   = chain[N_CELLS].tag;
        res_next.p     = chain[N_CELLS].neg ? -$signed(q + WORD_W'(rem)) : $signed(q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_time.sv]
// Mandelbrot escape-time unit.
// Input channel s_*: one point c per word, s_real_part and s_imag_part in
// signed fixed point with FRAC_BITS fraction bits. Output channel m_*: one
// m_iteration_count word per point. Configuration channel cfg_*: a write of
// cfg_data sets the iteration limit (reset value 256), clamped to the count
// range; write it only while the block is idle.
// Products run through a chain of four 32x32 multiplier cells plus an
// input and a rounding stage. The cardioid and bulb test runs before any
// iteration; each iteration is an update step followed by issuing and
// collecting three products. One point is in flight at a time.
// The finished count sits in an output register; a new point is accepted
// while it waits, and the block holds in its final state until the receiver
// takes the previous word. Synchronous active-low reset empties the output
// register, returns the sequencer to idle and restores the limit.
`timescale 1ns / 1ps
`default_nettype none

`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time
    import mee_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = 60,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [WORD_W-1:0] s_real_part,
    input  wire logic signed [WORD_W-1:0] s_imag_part,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [OUT_W-1:0]              m_iteration_count,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [LIMIT_W-1:0]       cfg_data
);

    localparam logic signed [WORD_W-1:0] FX_ONE   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [WORD_W-1:0] FX_HALF  = FX_ONE >>> 1;
    localparam logic signed [WORD_W-1:0] FX_QTR   = FX_ONE >>> 2;
    localparam logic signed [WORD_W-1:0] FX_3Q    = FX_ONE - FX_QTR;
    localparam logic signed [WORD_W-1:0] FX_3H    = FX_ONE + FX_HALF;
    localparam logic signed [WORD_W-1:0] FX_TWO   = FX_ONE <<< 1;
    localparam logic signed [WORD_W-1:0] FX_16TH  = FX_ONE >>> 4;
    localparam logic signed [WORD_W:0]   FX_FOUR  = 65'sd1 <<< (FRAC_BITS + 2);
    localparam logic signed [WORD_W-1:0] S_MAX    = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] S_MIN    = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [COUNT_WIDTH-1:0]   CMAX     = {COUNT_WIDTH{1'b1}};

    state_t                   state_reg, state_next;
    logic [LIMIT_W-1:0]       cfg_limit_reg;
    logic signed [WORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [COUNT_WIDTH-1:0]   limit_reg, limit_next, count_reg, count_next;
    logic signed [WORD_W-1:0] r2_reg, r2_next, i2_reg, i2_next, ri_reg, ri_next;
    logic signed [WORD_W-1:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [WORD_W-1:0] y2_reg, y2_next;
    logic                     bulb_reg, bulb_next;
    logic [1:0]               issue_reg, issue_next, got_reg, got_next;
    logic signed [WORD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic                     out_valid_reg;
    logic [COUNT_WIDTH-1:0]   out_count_reg;
    logic                     load_out;

    logic                     mul_valid;
    logic [1:0]               mul_tag;
    logic signed [WORD_W-1:0] mul_a, mul_b;
    mul_res_t                 mres;

    logic                     box_card, box_bulb, card_in, big;
    logic signed [WORD_W-1:0] xq, xp1, q, qx, zr_new, zi_new;
    logic signed [WORD_W:0]   mag2, zi_sum, zr_sum;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_iteration_count = OUT_W'(out_count_reg);

    // Hold the limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_limit_reg <= LIMIT_W'(256);
        end else if (cfg_valid) begin
            cfg_limit_reg <= cfg_data;
        end
    end

    mee_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (mul_valid),
        .in_tag   (mul_tag),
        .in_a     (mul_a),
        .in_b     (mul_b),
        .res      (mres)
    );

    // Collect products by tag
    always_ff @(posedge aclk) begin
        if (mres.valid) begin
            case (mres.tag)
                2'd0:    p0_reg <= mres.p;
                2'd1:    p1_reg <= mres.p;
                default: p2_reg <= mres.p;
            endcase
        end
    end

    // Datapath terms
    always_comb begin
        box_card = (x_reg >= -FX_ONE) && (x_reg <= FX_HALF) &&
                   (y_reg >= -FX_3Q) && (y_reg <= FX_3Q);
        box_bulb = (x_reg >= -FX_3H) && (x_reg <= -FX_HALF) &&
                   (y_reg >= -FX_HALF) && (y_reg <= FX_HALF);
        xq   = x_reg - FX_QTR;
        xp1  = x_reg + FX_ONE;
        q    = p1_reg + p0_reg;
        qx   = q + xq;
        card_in = box_card && (p0_reg <= (y2_reg >>> 2));
        mag2 = {r2_reg[WORD_W-1], r2_reg} + {i2_reg[WORD_W-1], i2_reg};
        zi_sum = {ri_reg[WORD_W-1], ri_reg <<< 1} + {y_reg[WORD_W-1], y_reg};
        zr_sum = {r2_reg[WORD_W-1], r2_reg} - {i2_reg[WORD_W-1], i2_reg}
                 + {x_reg[WORD_W-1], x_reg};
        zi_new = (zi_sum[WORD_W] != zi_sum[WORD_W-1]) ?
                 (zi_sum[WORD_W] ? S_MIN : S_MAX) : zi_sum[WORD_W-1:0];
        zr_new = (zr_sum[WORD_W] != zr_sum[WORD_W-1]) ?
                 (zr_sum[WORD_W] ? S_MIN : S_MAX) : zr_sum[WORD_W-1:0];
        big = (zr_new >= FX_TWO) || (zr_new <= -FX_TWO) ||
              (zi_new >= FX_TWO) || (zi_new <= -FX_TWO);
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        x_next = x_reg;  y_next = y_reg;
        limit_next = limit_reg;  count_next = count_reg;
        r2_next = r2_reg;  i2_next = i2_reg;  ri_next = ri_reg;
        zr_next = zr_reg;  zi_next = zi_reg;
        y2_next = y2_reg;  bulb_next = bulb_reg;
        issue_next = issue_reg;
        got_next = got_reg + 2'(mres.valid);
        mul_valid = 1'b0;  mul_tag = issue_reg;
        mul_a = zr_reg;  mul_b = zr_reg;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    x_next = s_real_part;
                    y_next = s_imag_part;
                    limit_next = (33'(cfg_limit_reg) >= 33'(CMAX)) ?
                                 CMAX : COUNT_WIDTH'(cfg_limit_reg);
                    count_next = '0;
                    issue_next = '0;
                    got_next = '0;
                    state_next = S_SKIP_A;
                end
            end
            S_SKIP_A: begin
                if (issue_reg != 2'd3) begin
                    mul_valid = 1'b1;
                    issue_next = issue_reg + 2'd1;
                    case (issue_reg)
                        2'd0:    begin mul_a = y_reg; mul_b = y_reg; end
                        2'd1:    begin mul_a = xq;    mul_b = xq;    end
                        default: begin mul_a = xp1;   mul_b = xp1;   end
                    endcase
                end
                if (got_reg == 2'd3) begin
                    y2_next = p0_reg;
                    bulb_next = box_bulb && ((p2_reg + p0_reg) <= FX_16TH);
                    issue_next = '0;
                    got_next = '0;
                    state_next = S_SKIP_B;
                end
            end
            S_SKIP_B: begin
                if (issue_reg == 2'd0) begin
                    mul_valid = 1'b1;
                    mul_a = q;
                    mul_b = qx;
                    issue_next = 2'd1;
                end
                if (got_reg == 2'd1) begin
                    r2_next = '0;  i2_next = '0;  ri_next = '0;
                    if (card_in || bulb_reg) begin
                        count_next = limit_reg;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ITER;
                    end
                end
            end
            S_ITER: begin
                if ((count_reg >= limit_reg) || (mag2 >= FX_FOUR)) begin
                    state_next = S_DONE;
                end else begin
                    count_next = count_reg + 1'b1;
                    zr_next = zr_new;
                    zi_next = zi_new;
                    issue_next = '0;
                    got_next = '0;
                    state_next = big ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                if (issue_reg != 2'd3) begin
                    mul_valid = 1'b1;
                    issue_next = issue_reg + 2'd1;
                    case (issue_reg)
                        2'd0:    begin mul_a = zr_reg; mul_b = zr_reg; end
                        2'd1:    begin mul_a = zi_reg; mul_b = zi_reg; end
                        default: begin mul_a = zr_reg; mul_b = zi_reg; end
                    endcase
                end
                if (got_reg == 2'd3) begin
                    r2_next = p0_reg;
                    i2_next = p1_reg;
                    ri_next = p2_reg;
                    state_next = S_ITER;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            issue_reg <= '0;
            got_reg   <= '0;
        end else begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            got_reg   <= got_next;
        end
    end

    // Hold point data
    always_ff @(posedge aclk) begin
        x_reg <= x_next;  y_reg <= y_next;
        limit_reg <= limit_next;  count_reg <= count_next;
        r2_reg <= r2_next;  i2_reg <= i2_next;  ri_reg <= ri_next;
        zr_reg <= zr_next;  zi_reg <= zi_next;
        y2_reg <= y2_next;  bulb_reg <= bulb_next;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_count_reg <= count_reg;
        end
    end

    `MEE_ASSERT_NOW(a_count_bound, aclk, aresetn, state_reg == S_ITER, count_reg <= limit_reg)
    `MEE_ASSERT_NOW(a_res_expected, aclk, aresetn, mres.valid, (state_reg == S_SKIP_A) || (state_reg == S_SKIP_B) || (state_reg == S_MUL))
    `MEE_ASSERT_NEXT(a_accept_start, aclk, aresetn, s_valid && s_ready, state_reg == S_SKIP_A)

endmodule

`default_nettype wire
